### rtl/core/assert_macros.svh
// Assertion macros for the checker file of the deframer.
// Depends on nothing; included by bare name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/ufd_pkg.sv
// Types and constants of the uplink frame deframer.
// Depends on nothing; imported by every module and interface of the block.
package ufd_pkg;

   localparam int CHECK_SPAN = 22;

   localparam logic [7:0] SYNC_GAIN_RUN = 8'd3;
   localparam logic [7:0] SYNC_LOSS_RUN = 8'd5;
   localparam logic [7:0] RUN_MAX       = 8'd255;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL   = 8'd1;

   typedef struct packed {
      logic [7:0] rx_byte;
   } ufd_req_type;

   typedef struct packed {
      logic               frame_ok;
      logic [7:0]         stop_flag;
      logic signed [15:0] lin_x;
      logic signed [15:0] lin_y;
      logic signed [15:0] lin_z;
      logic signed [15:0] ang_x;
      logic signed [15:0] ang_y;
      logic signed [15:0] ang_z;
      logic signed [15:0] wheel_count_a;
      logic signed [15:0] wheel_count_b;
      logic signed [15:0] battery_raw;
      logic               in_sync;
   } ufd_rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [7:0]           wr_data;
   } ufd_csr_type;

   // One checked frame handed to the sync tracker.
   typedef struct packed {
      logic valid;
      logic ok;
   } ufd_frame_type;

endpackage

### rtl/core/ufd_chan_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Depends on ufd_pkg for the payload types.
interface ufd_chan_if
   import ufd_pkg::*;
#(
   parameter type payload_type = ufd_req_type
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

### rtl/core/ufd_cell.sv
// One byte cell of the sliding frame window.
// Depends on ufd_pkg; instantiated in a row by uplink_frame_deframer.
module ufd_cell
   import ufd_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] byte_in,
   output logic [7:0] byte_out
);

   logic [7:0] byte_ff;

   // The window holds payload only, so the cell needs no reset.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

### rtl/core/ufd_sync_tracker.sv
// Good/bad frame run counters and the stream synchronization flag.
// Depends on ufd_pkg for the frame event type and run thresholds.
module ufd_sync_tracker
   import ufd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ufd_frame_type frame,
   output logic          sync_next
);

   logic [7:0] good_run_ff;
   logic [7:0] good_run_in;
   logic [7:0] bad_run_ff;
   logic [7:0] bad_run_in;
   logic       sync_ff;
   logic       sync_in;

   always_comb begin
      good_run_in = good_run_ff;
      bad_run_in  = bad_run_ff;
      sync_in     = sync_ff;
      if (frame.valid) begin
         if (frame.ok) begin
            good_run_in = (good_run_ff == RUN_MAX) ? good_run_ff : good_run_ff + 8'd1;
            bad_run_in  = '0;
            if (good_run_in >= SYNC_GAIN_RUN) begin
               sync_in = 1'b1;
            end
         end else begin
            bad_run_in  = (bad_run_ff == RUN_MAX) ? bad_run_ff : bad_run_ff + 8'd1;
            good_run_in = '0;
            if (bad_run_in >= SYNC_LOSS_RUN) begin
               sync_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         good_run_ff <= '0;
         bad_run_ff  <= '0;
         sync_ff     <= 1'b0;
      end else begin
         good_run_ff <= good_run_in;
         bad_run_ff  <= bad_run_in;
         sync_ff     <= sync_in;
      end
   end

   // The result reports the flag as updated by this frame.
   assign sync_next = sync_in;

endmodule

### rtl/core/ufd_out_skid.sv
// Two-entry output register (main stage plus skid) for decoded frames.
// Depends on ufd_pkg and ufd_chan_if.
module ufd_out_skid
   import ufd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ufd_rsp_type push_data,
   output logic        room,
   ufd_chan_if.source  rsp_ch
);

   logic        out_valid_ff;
   ufd_rsp_type out_data_ff;
   logic        skid_valid_ff;
   ufd_rsp_type skid_data_ff;
   logic        out_free;

   // The main stage can load when empty or when its result leaves now.
   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end
      if (!out_free && push) begin
         skid_data_ff <= push_data;
      end
   end

   assign room           = !skid_valid_ff;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

endmodule

### rtl/core/uplink_frame_deframer.sv
// Top level of the uplink frame deframer: byte window, frame check, sync, output.
// Depends on ufd_pkg, ufd_chan_if, ufd_cell, ufd_sync_tracker and ufd_out_skid.
//
//   Channel  Direction  Payload                          Transfer when
//   req_ch   in         rx_byte                          req_ch.valid && req_ch.ready
//   rsp_ch   out        frame_ok .. in_sync (decoded)    rsp_ch.valid && rsp_ch.ready
//   csr_ch   in         reg_index, wr_data               csr_ch.valid && csr_ch.ready
//
// One byte is taken per clock cycle while req_ch.ready is high; the row of window cells
// shifts once per byte transfer and the frame test and XOR check run on the shifted
// window in that cycle; a decoded frame is registered into the output stage or skid.
// The two-entry output register lets bytes keep flowing while one result waits;
// req_ch.ready drops only when both entries are full. csr_ch is always ready.
// Reset is synchronous; the window itself is not cleared, its fill count is.
module uplink_frame_deframer
   import ufd_pkg::*;
#(
   parameter int FRAME_LEN = 24
) (
   input  logic       clock,
   input  logic       reset,
   ufd_chan_if.sink   req_ch,
   ufd_chan_if.source rsp_ch,
   ufd_chan_if.sink   csr_ch
);

   localparam int FILL_W = $clog2(FRAME_LEN + 1);

   logic [7:0]        header_ff;
   logic [7:0]        tail_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              req_xfer;
   logic              room;
   logic              full_next;
   logic              frame_hit;
   logic [7:0]        check_sum;
   logic              sync_next;
   ufd_frame_type     frame;
   ufd_rsp_type       rsp_data;

   // win_q holds the cells; win_in is the window after this byte shifts in.
   // The oldest byte leaves the window on every shift, so position zero needs no cell.
   logic [7:0] win_q  [1:FRAME_LEN-1];
   logic [7:0] win_in [FRAME_LEN];

   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = room;
   assign csr_ch.ready = 1'b1;

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         tail_ff   <= '0;
      end else if (csr_ch.valid) begin
         if (csr_ch.payload.reg_index == CSR_HEADER) begin
            header_ff <= csr_ch.payload.wr_data;
         end
         if (csr_ch.payload.reg_index == CSR_TAIL) begin
            tail_ff <= csr_ch.payload.wr_data;
         end
      end
   end

   // Each cell takes its right neighbor's byte; the last cell takes the new byte.
   for (genvar k = 0; k < FRAME_LEN; k++) begin : g_cell
      if (k == FRAME_LEN - 1) begin : g_last
         assign win_in[k] = req_ch.payload.rx_byte;
      end else begin : g_mid
         assign win_in[k] = win_q[k+1];
      end
      if (k > 0) begin : g_store
         ufd_cell u_cell (
            .clock    (clock),
            .shift_en (req_xfer),
            .byte_in  (win_in[k]),
            .byte_out (win_q[k])
         );
      end
   end

   // The window is full after this byte once the count has reached FRAME_LEN - 1.
   assign full_next = (fill_ff >= FILL_W'(FRAME_LEN - 1));
   assign frame_hit = full_next && (win_in[0] == header_ff) &&
                      (win_in[FRAME_LEN-1] == tail_ff);

   always_comb begin
      fill_in = fill_ff;
      if (req_xfer) begin
         if (frame_hit) begin
            fill_in = '0;
         end else if (!full_next) begin
            fill_in = fill_ff + 1'b1;
         end else begin
            fill_in = FILL_W'(FRAME_LEN);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // XOR over the check span of the shifted window; synthesis builds a tree.
   always_comb begin
      check_sum = '0;
      for (int i = 0; i < CHECK_SPAN; i++) begin
         check_sum = check_sum ^ win_in[i];
      end
   end

   assign frame.valid = req_xfer && frame_hit;
   assign frame.ok    = (check_sum == win_in[CHECK_SPAN]);

   ufd_sync_tracker u_sync (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .sync_next (sync_next)
   );

   always_comb begin
      rsp_data.frame_ok      = frame.ok;
      rsp_data.stop_flag     = win_in[1];
      rsp_data.lin_x         = {win_in[2], win_in[3]};
      rsp_data.lin_y         = {win_in[4], win_in[5]};
      rsp_data.lin_z         = {win_in[6], win_in[7]};
      rsp_data.ang_x         = {win_in[8], win_in[9]};
      rsp_data.ang_y         = {win_in[10], win_in[11]};
      rsp_data.ang_z         = {win_in[12], win_in[13]};
      rsp_data.wheel_count_a = {win_in[14], win_in[15]};
      rsp_data.wheel_count_b = {win_in[16], win_in[17]};
      rsp_data.battery_raw   = {win_in[20], win_in[21]};
      rsp_data.in_sync       = sync_next;
   end

   ufd_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (frame.valid),
      .push_data (rsp_data),
      .room      (room),
      .rsp_ch    (rsp_ch)
   );

endmodule

### rtl/core/ufd_checker.sv
// Port-level checks of the deframer, bound to the top level.
// Depends on ufd_pkg, assert_macros.svh and uplink_frame_deframer.
`include "assert_macros.svh"

module ufd_checker
   import ufd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input ufd_rsp_type rsp_payload
);

   // A new result only ever follows a byte transfer.
   `UFD_ASSERT_NOW(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready), "result without a byte transfer")

   // Input stalls only while a result is held at the output.
   `UFD_ASSERT_NOW(a_stall_needs_rsp, clock, reset, !req_ready, rsp_valid, "input stalled with empty output")

   // A result held by back pressure stays in place.
   `UFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")

endmodule

bind uplink_frame_deframer ufd_checker u_ufd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

### tb/sv/uplink_frame_deframer_tb.sv
// Self-checking testbench of the uplink frame deframer: byte stimulus, frame predictor, checks.
// Depends on ufd_pkg, ufd_chan_if and the uplink_frame_deframer RTL.
`timescale 1ns / 1ps

module uplink_frame_deframer_tb;
   import ufd_pkg::*;

   localparam int FRAME_BYTES = 24;
   // Index that matches no register; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'hC3;
   // Cycles allowed for a tail byte to reach the output after the last expected result.
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_BYTES = 215;
   localparam int NUM_PHASES = 7;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // Predicts the decoded frames from the accepted bytes and checks the results against them.
   class frame_scoreboard;
      logic [7:0]  header_byte;
      logic [7:0]  tail_byte;
      logic [7:0]  window [FRAME_BYTES];
      int unsigned fill;
      logic [7:0]  good_run;
      logic [7:0]  bad_run;
      logic        synced;
      ufd_rsp_type pending [$];
      int          errors;

      function void clear_state();
         header_byte = '0;
         tail_byte = '0;
         foreach (window[i]) window[i] = '0;
         fill = 0;
         good_run = '0;
         bad_run = '0;
         synced = 1'b0;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [7:0] data);
         if (index == CSR_HEADER) header_byte = data;
         else if (index == CSR_TAIL) tail_byte = data;
      endfunction

      function void note_byte(logic [7:0] value);
         logic [7:0]  sum;
         logic        ok;
         ufd_rsp_type frame;
         for (int i = 0; i < FRAME_BYTES - 1; i++) window[i] = window[i + 1];
         window[FRAME_BYTES - 1] = value;
         if (fill < FRAME_BYTES) fill++;
         if (fill < FRAME_BYTES || window[0] != header_byte ||
             window[FRAME_BYTES - 1] != tail_byte) return;
         fill = 0;
         sum = '0;
         for (int i = 0; i < CHECK_SPAN; i++) sum ^= window[i];
         ok = (sum == window[CHECK_SPAN]);
         if (ok) begin
            if (good_run != RUN_MAX) good_run++;
            bad_run = '0;
            if (good_run >= SYNC_GAIN_RUN) synced = 1'b1;
         end else begin
            if (bad_run != RUN_MAX) bad_run++;
            good_run = '0;
            if (bad_run >= SYNC_LOSS_RUN) synced = 1'b0;
         end
         frame.frame_ok      = ok;
         frame.stop_flag     = window[1];
         frame.lin_x         = {window[2], window[3]};
         frame.lin_y         = {window[4], window[5]};
         frame.lin_z         = {window[6], window[7]};
         frame.ang_x         = {window[8], window[9]};
         frame.ang_y         = {window[10], window[11]};
         frame.ang_z         = {window[12], window[13]};
         frame.wheel_count_a = {window[14], window[15]};
         frame.wheel_count_b = {window[16], window[17]};
         frame.battery_raw   = {window[20], window[21]};
         frame.in_sync       = synced;
         pending = {pending, frame};
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(ufd_rsp_type got);
         ufd_rsp_type want;
         if (pending.size() == 0) begin
            $error("result transfer with no frame expected");
            errors++;
            return;
         end
         want = pending[0];
         pending.delete(0);
         check_field("frame_ok", want.frame_ok, got.frame_ok);
         check_field("stop_flag", want.stop_flag, got.stop_flag);
         check_field("lin_x", want.lin_x, got.lin_x);
         check_field("lin_y", want.lin_y, got.lin_y);
         check_field("lin_z", want.lin_z, got.lin_z);
         check_field("ang_x", want.ang_x, got.ang_x);
         check_field("ang_y", want.ang_y, got.ang_y);
         check_field("ang_z", want.ang_z, got.ang_z);
         check_field("wheel_count_a", want.wheel_count_a, got.wheel_count_a);
         check_field("wheel_count_b", want.wheel_count_b, got.wheel_count_b);
         check_field("battery_raw", want.battery_raw, got.battery_raw);
         check_field("in_sync", want.in_sync, got.in_sync);
      endfunction
   endclass

   logic clock;
   logic reset;

   ufd_chan_if #(.payload_type(ufd_req_type)) req_if ();
   ufd_chan_if #(.payload_type(ufd_rsp_type)) rsp_if ();
   ufd_chan_if #(.payload_type(ufd_csr_type)) csr_if ();

   uplink_frame_deframer #(
      .FRAME_LEN(FRAME_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   frame_scoreboard sb;
   int unsigned     send_idle_pct;
   int unsigned     recv_stall_pct;
   int unsigned     bytes_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs; the slowest legal run needs far less than this.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Result side. Outputs are sampled right after the edge, so they still hold the values
   // that were present at the edge. The ready line stalls at random by the current mode.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void set_idle_mode(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 59;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 59;
         end
         default: begin
            send_idle_pct = 19;
            recv_stall_pct = 19;
         end
      endcase
   endfunction

   // One byte transfer. Valid stays high across back-to-back bytes; it only drops for the
   // random idle cycles taken in front of a byte and while results are drained.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload.rx_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      sb.note_byte(value);
      bytes_sent++;
   endtask

   // The sender holds off until every predicted frame has come out, then lets the block
   // settle, so that a register write never lands while a tail byte is in flight.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [7:0] data);
      csr_if.valid <= 1'b1;
      csr_if.payload.reg_index <= index;
      csr_if.payload.wr_data <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_register(index, data);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends header, data bytes 1..21 (stop byte first), the XOR check byte and the tail.
   // A failed check flips at least one bit of the check byte. With keep below the full
   // frame length only the first bytes go out, which leaves a header without its tail.
   task automatic send_frame(input logic [7:0] data [1:21], input bit good, input int keep);
      logic [7:0] frame [FRAME_BYTES];
      logic [7:0] sum;
      frame[0] = sb.header_byte;
      sum = sb.header_byte;
      for (int i = 1; i <= 21; i++) begin
         frame[i] = data[i];
         sum ^= data[i];
      end
      frame[CHECK_SPAN] = good ? sum : sum ^ 8'($urandom_range(1, 255));
      frame[FRAME_BYTES - 1] = sb.tail_byte;
      for (int i = 0; i < keep; i++) send_byte(frame[i]);
   endtask

   task automatic send_random_frame(input bit good, input int keep);
      logic [7:0] data [1:21];
      foreach (data[i]) data[i] = 8'($urandom);
      send_frame(data, good, keep);
   endtask

   // Random traffic for one phase: mostly whole frames in runs, with bursts of failed
   // frames long enough to drop sync, plus noise, cut-off frames and the odd full pause.
   task automatic run_random_phase();
      int unsigned phase_end;
      int unsigned pick;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 30)) send_byte(8'($urandom));
         end else if (pick < 22) begin
            send_random_frame($urandom_range(1), $urandom_range(1, FRAME_BYTES - 1));
         end else if (pick < 30) begin
            repeat ($urandom_range(5, 8)) send_random_frame(1'b0, FRAME_BYTES);
         end else if (pick < 33) begin
            drain_results();
         end else begin
            repeat ($urandom_range(1, 6))
               send_random_frame($urandom_range(9) != 0, FRAME_BYTES);
         end
      end
   endtask

   initial begin
      logic [7:0] header_set [NUM_PHASES];
      logic [7:0] tail_set [NUM_PHASES];
      logic [7:0] corner [1:21];

      // Register settings per phase: typical values, both extremes, header equal to tail
      // and, last, a random pair.
      header_set = '{8'hAA, 8'h00, 8'hFF, 8'h7E, 8'h00, 8'hFF, 8'($urandom)};
      tail_set   = '{8'h55, 8'hFF, 8'h00, 8'h7E, 8'h00, 8'hFF, 8'($urandom)};

      // Stop byte at its top value, then words at both signed extremes, zero, minus one
      // and mixed byte patterns; bytes 18 and 19 are not decoded.
      corner = '{8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00,
                 8'h01, 8'h80, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h7F,
                 8'h80};

      sb = new();
      sb.clear_state();
      bytes_sent = 0;
      set_idle_mode(IDLE_NONE);
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A write to an index that names no register must leave both registers alone.
      write_reg(CSR_UNUSED, 8'h3C);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         write_reg(CSR_HEADER, header_set[phase]);
         write_reg(CSR_TAIL, tail_set[phase]);
         set_idle_mode(idle_mode_type'(phase % 4));
         if (phase == 0) begin
            // Directed: one good frame carrying the field extremes, then a lone header
            // that ages out of the window without its tail.
            send_frame(corner, 1'b1, FRAME_BYTES);
            send_byte(header_set[phase]);
         end
         run_random_phase();
      end

      drain_results();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
